/* rtl/core/mhoc_pkg.sv */
// Shared types and constants for the max-heap order checker.
// No dependencies; every other file in rtl/core uses it by scoped names.
package mhoc_pkg;

	localparam int COORD_W = 16;
	localparam int SQ_W    = 2 * COORD_W - 1;
	localparam int DIST_W  = 2 * COORD_W;
	localparam int COUNT_W = 8;

	localparam logic [1:0] MODE_XY   = 2'd0;
	localparam logic [1:0] MODE_YX   = 2'd1;
	localparam logic [1:0] MODE_DIST = 2'd2;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic                      last;
	} point_t;

	typedef struct packed {
		logic               heap_ok;
		logic [COUNT_W-1:0] point_count;
	} result_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} coord_t;

	// Control that travels with each request down the pipeline.
	typedef struct packed {
		logic valid;
		logic last;
		logic check;
	} stage_ctrl_t;

endpackage

/* rtl/core/mhoc_store.sv */
// Point store, write index and parent read for the max-heap order checker.
// Depends on mhoc_pkg.
module mhoc_store #(
	parameter int MAX_POINTS = 128,
	parameter int IDX_W      = $clog2(MAX_POINTS),
	parameter int CNT_W      = $clog2(MAX_POINTS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  accept,
	input  mhoc_pkg::point_t      point,
	output mhoc_pkg::stage_ctrl_t ctrl_s1,
	output mhoc_pkg::coord_t      child_s1,
	output mhoc_pkg::coord_t      parent_s1,
	output logic [CNT_W-1:0]      count_s1
);

	mhoc_pkg::coord_t store_mem [MAX_POINTS];

	logic [CNT_W-1:0] next_index_q;
	logic             full;
	logic [CNT_W-1:0] count_next;
	logic [CNT_W-1:0] parent_wide;
	logic [IDX_W-1:0] parent_addr;
	logic [IDX_W-1:0] write_addr;

	assign full        = (next_index_q == CNT_W'(MAX_POINTS));
	assign count_next  = full ? next_index_q : next_index_q + CNT_W'(1);
	assign parent_wide = (next_index_q - CNT_W'(1)) >> 1;
	assign parent_addr = parent_wide[IDX_W-1:0];
	assign write_addr  = next_index_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_index_q <= '0;
		end else if (accept) begin
			next_index_q <= point.last ? '0 : count_next;
		end
	end

	// Write the new point; the parent always landed in an earlier cycle.
	always_ff @(posedge clk) begin
		if (accept && !full) begin
			store_mem[write_addr] <= '{x: point.point_x, y: point.point_y};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			parent_s1 <= store_mem[parent_addr];
			child_s1  <= '{x: point.point_x, y: point.point_y};
			count_s1  <= count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (adv) begin
			ctrl_s1.valid <= accept;
			ctrl_s1.last  <= point.last;
			ctrl_s1.check <= !full && (next_index_q != '0);
		end
	end

endmodule

/* rtl/core/mhoc_order.sv */
// Ordering stage: squares the coordinates, then compares parent and child.
// Depends on mhoc_pkg.
module mhoc_order #(
	parameter int CNT_W = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic [1:0]            mode,
	input  mhoc_pkg::stage_ctrl_t ctrl_s1,
	input  mhoc_pkg::coord_t      child_s1,
	input  mhoc_pkg::coord_t      parent_s1,
	input  logic [CNT_W-1:0]      count_s1,
	output mhoc_pkg::stage_ctrl_t ctrl_s2,
	output logic [CNT_W-1:0]      count_s2,
	output logic                  below
);

	logic signed [mhoc_pkg::DIST_W-1:0] prod_px, prod_py, prod_cx, prod_cy;

	mhoc_pkg::coord_t                 child_s2, parent_s2;
	logic [mhoc_pkg::SQ_W-1:0]        sq_px_s2, sq_py_s2, sq_cx_s2, sq_cy_s2;
	logic [mhoc_pkg::DIST_W-1:0]      dist_p, dist_c;
	logic x_lt, x_eq, y_lt, y_eq, d_lt, d_eq;

	assign prod_px = parent_s1.x * parent_s1.x;
	assign prod_py = parent_s1.y * parent_s1.y;
	assign prod_cx = child_s1.x * child_s1.x;
	assign prod_cy = child_s1.y * child_s1.y;

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_px_s2  <= prod_px[mhoc_pkg::SQ_W-1:0];
			sq_py_s2  <= prod_py[mhoc_pkg::SQ_W-1:0];
			sq_cx_s2  <= prod_cx[mhoc_pkg::SQ_W-1:0];
			sq_cy_s2  <= prod_cy[mhoc_pkg::SQ_W-1:0];
			child_s2  <= child_s1;
			parent_s2 <= parent_s1;
			count_s2  <= count_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else if (adv) begin
			ctrl_s2 <= ctrl_s1;
		end
	end

	assign dist_p = {1'b0, sq_px_s2} + {1'b0, sq_py_s2};
	assign dist_c = {1'b0, sq_cx_s2} + {1'b0, sq_cy_s2};

	assign x_lt = parent_s2.x < child_s2.x;
	assign x_eq = parent_s2.x == child_s2.x;
	assign y_lt = parent_s2.y < child_s2.y;
	assign y_eq = parent_s2.y == child_s2.y;
	assign d_lt = dist_p < dist_c;
	assign d_eq = dist_p == dist_c;

	// Parent orders strictly below its child under the selected mode.
	always_comb begin
		case (mode)
			mhoc_pkg::MODE_XY:   below = x_lt || (x_eq && y_lt);
			mhoc_pkg::MODE_YX:   below = y_lt || (y_eq && x_lt);
			mhoc_pkg::MODE_DIST: below = d_lt || (d_eq && (x_lt || (x_eq && y_lt)));
			default:             below = 1'b0;
		endcase
	end

endmodule

/* rtl/core/max_heap_order_checker.sv */
// Max-heap order checker: top level with the order flag and result register.
// Depends on mhoc_pkg, mhoc_store and mhoc_order.
//
// Usage:
//   Points enter on the point channel (point_valid / point_stall) in array
//   order; point.last marks the final element of one array. A request on
//   the result channel (result_valid / result_stall) follows each last
//   point and carries heap_ok and point_count, the count capped at
//   MAX_POINTS and reduced to its low 8 bits. Other points give no result.
//   The user must write the ordering mode through cfg_valid / cfg_ready /
//   cfg_data only while idle (not enforced); cfg_ready is always high.
// Timing:
//   One point is taken every cycle while point_stall is low. A result is
//   valid once its last point has passed the store read register, loaded
//   on the taking edge, the squaring register and the result register.
//   Points beyond MAX_POINTS are neither stored nor compared.
// Reset and stall:
//   arst_n clears the write index, the order flag (to one), the mode (to
//   x then y) and all valid bits. The store needs no clearing. While the
//   result register holds an untaken request and result_stall is high,
//   the whole pipeline holds and point_stall is raised.
module max_heap_order_checker #(
	parameter int MAX_POINTS = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              point_valid,
	output logic              point_stall,
	input  mhoc_pkg::point_t  point,
	output logic              result_valid,
	input  logic              result_stall,
	output mhoc_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_data
);

	localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	logic                  adv;
	logic                  accept;
	logic [1:0]            mode_q;
	logic                  flag_q;
	logic                  result_valid_q;
	mhoc_pkg::result_t     result_q;
	mhoc_pkg::stage_ctrl_t ctrl_s1, ctrl_s2;
	mhoc_pkg::coord_t      child_s1, parent_s1;
	logic [CNT_W-1:0]      count_s1, count_s2;
	logic                  below;
	logic                  violation;
	logic [CNT_W+7:0]      count_ext;

	// Advance the whole pipeline unless the result register is held.
	assign adv         = !result_valid_q || !result_stall;
	assign point_stall = !adv;
	assign accept      = point_valid && adv;
	assign cfg_ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= mhoc_pkg::MODE_XY;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	mhoc_store #(
		.MAX_POINTS (MAX_POINTS),
		.IDX_W      (IDX_W),
		.CNT_W      (CNT_W)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.accept    (accept),
		.point     (point),
		.ctrl_s1   (ctrl_s1),
		.child_s1  (child_s1),
		.parent_s1 (parent_s1),
		.count_s1  (count_s1)
	);

	mhoc_order #(
		.CNT_W (CNT_W)
	) u_order (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.mode      (mode_q),
		.ctrl_s1   (ctrl_s1),
		.child_s1  (child_s1),
		.parent_s1 (parent_s1),
		.count_s1  (count_s1),
		.ctrl_s2   (ctrl_s2),
		.count_s2  (count_s2),
		.below     (below)
	);

	// Only a stored, non-root point can break the heap order.
	assign violation = ctrl_s2.check && below;
	assign count_ext = {8'b0, count_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q         <= 1'b1;
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= ctrl_s2.valid && ctrl_s2.last;
			if (ctrl_s2.valid) begin
				// Re-arm the flag after the last point of an array.
				flag_q <= ctrl_s2.last ? 1'b1 : (flag_q && !violation);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctrl_s2.valid && ctrl_s2.last) begin
			result_q.heap_ok     <= flag_q && !violation;
			result_q.point_count <= count_ext[7:0];
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

/* tb/max_heap_order_checker_tb.sv */
// Testbench for max_heap_order_checker: a scoreboard with its own heap-order predictor, plus
// the top module that drives points, mode writes and result stalls.
// Depends on mhoc_pkg and the RTL of max_heap_order_checker.

module max_heap_order_checker_tb;

	class heap_verdict_board #(int CAPACITY = 128);

		logic [1:0]          mode;
		mhoc_pkg::coord_t    store [CAPACITY];
		int                  fill;
		bit                  in_order;
		mhoc_pkg::result_t   pending_verdicts[$];
		int                  errors;

		function new();
			mode     = mhoc_pkg::MODE_XY;
			fill     = 0;
			in_order = 1'b1;
			errors   = 0;
		endfunction

		function void set_mode(logic [1:0] m);
			mode = m;
		endfunction

		function int sign_of(longint a, longint b);
			if (a > b) return 1;
			if (a < b) return -1;
			return 0;
		endfunction

		// 1 when a orders above b, -1 below, 0 equal
		function int rank_points(mhoc_pkg::coord_t a, mhoc_pkg::coord_t b);
			longint da;
			longint db;
			int     r;
			da = longint'(a.x) * a.x + longint'(a.y) * a.y;
			db = longint'(b.x) * b.x + longint'(b.y) * b.y;
			case (mode)
				mhoc_pkg::MODE_XY: begin
					r = sign_of(a.x, b.x);
					if (r == 0) r = sign_of(a.y, b.y);
				end
				mhoc_pkg::MODE_YX: begin
					r = sign_of(a.y, b.y);
					if (r == 0) r = sign_of(a.x, b.x);
				end
				mhoc_pkg::MODE_DIST: begin
					r = sign_of(da, db);
					if (r == 0) r = sign_of(a.x, b.x);
					if (r == 0) r = sign_of(a.y, b.y);
				end
				default: r = 0;
			endcase
			return r;
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 10) $display("ERROR %0t: %s", $time, msg);
		endfunction

		function void note_point(mhoc_pkg::point_t p);
			mhoc_pkg::coord_t  c;
			mhoc_pkg::result_t r;
			c.x = p.point_x;
			c.y = p.point_y;
			// points past capacity are dropped, but a last mark still closes the array
			if (fill < CAPACITY) begin
				store[fill] = c;
				if (fill > 0 && rank_points(store[(fill - 1) / 2], c) < 0) in_order = 1'b0;
				fill++;
			end
			if (p.last) begin
				r.heap_ok     = in_order;
				r.point_count = mhoc_pkg::COUNT_W'(fill);
				pending_verdicts.push_back(r);
				fill     = 0;
				in_order = 1'b1;
			end
		endfunction

		function void check_verdict(mhoc_pkg::result_t got);
			mhoc_pkg::result_t want;
			if (pending_verdicts.size() == 0) begin
				report($sformatf("unexpected result heap_ok=%0b point_count=%0d",
					got.heap_ok, got.point_count));
				return;
			end
			want = pending_verdicts.pop_front();
			if (got.heap_ok !== want.heap_ok || got.point_count !== want.point_count)
				report($sformatf(
					"expected heap_ok=%0b point_count=%0d, got heap_ok=%0b point_count=%0d",
					want.heap_ok, want.point_count, got.heap_ok, got.point_count));
		endfunction

		function void close_out();
			if (pending_verdicts.size() != 0)
				report($sformatf("%0d results never arrived", pending_verdicts.size()));
		endfunction

	endclass

	localparam int         CAPACITY   = 128;
	localparam logic [1:0] MODE_NONE  = 2'd3;	// unused mode: every pair orders equal
	localparam int         LONG_HOLD  = 400;
	localparam int         DRAIN      = 8;
	localparam int         IDLE_LIMIT = 20000;
	localparam int         PHASE_ITEMS = 210;
	localparam longint     WATCHDOG   = 3_000_000;

	typedef heap_verdict_board #(CAPACITY) board_t;

	logic              clk;
	logic              arst_n;
	logic              point_valid;
	logic              point_stall;
	mhoc_pkg::point_t  point;
	logic              result_valid;
	logic              result_stall;
	mhoc_pkg::result_t result;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_data;

	board_t sb = new();

	mhoc_pkg::coord_t pts[$];	// array being built for the next send
	int               burst_left;
	int               items_taken = 0;
	bit               hold_done = 1'b0;

	max_heap_order_checker #(
		.MAX_POINTS(CAPACITY)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.point_valid  (point_valid),
		.point_stall  (point_stall),
		.point        (point),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#(WATCHDOG);
		$display("Regression FAIL");
		$finish;
	end

	// Sample both channels at the edge; values seen here are the pre-edge ones,
	// so a request counts exactly when the block takes it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) sb.check_verdict(result);
			if (point_valid && !point_stall) begin
				sb.note_point(point);
				items_taken++;
			end
		end
	end

	// Receiver: stall in stretches of varying density, and once hold off for a
	// long stretch so the pipeline backs up into the point channel.
	initial begin
		int span;
		int pct;
		result_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!hold_done && items_taken >= 700) begin
				hold_done = 1'b1;
				repeat (LONG_HOLD) begin
					@(posedge clk);
					result_stall <= 1'b1;
				end
			end else begin
				case ($urandom_range(0, 3))
					0:       pct = 0;
					1:       pct = 30;
					2:       pct = 60;
					default: pct = 90;
				endcase
				span = $urandom_range(4, 60);
				repeat (span) begin
					@(posedge clk);
					result_stall <= ($urandom_range(0, 99) < pct);
				end
			end
		end
	end

	// Offer one request and hold it until taken; end a burst with a random gap.
	task automatic send_point(mhoc_pkg::point_t p);
		point       <= p;
		point_valid <= 1'b1;
		do @(posedge clk); while (point_stall);
		burst_left--;
		if (burst_left <= 0) begin
			point_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
	endtask

	task automatic send_array();
		mhoc_pkg::point_t p;
		for (int i = 0; i < pts.size(); i++) begin
			p.point_x = pts[i].x;
			p.point_y = pts[i].y;
			p.last    = (i == pts.size() - 1);
			send_point(p);
		end
		pts.delete();
	endtask

	task automatic add_pt(int x, int y);
		mhoc_pkg::coord_t c;
		c.x = mhoc_pkg::COORD_W'(x);
		c.y = mhoc_pkg::COORD_W'(y);
		pts.push_back(c);
	endtask

	// Drop valid, wait out all pending results, then let the pipeline drain.
	task automatic wait_idle();
		int guard;
		guard = 0;
		point_valid <= 1'b0;
		do begin
			@(posedge clk);
			guard++;
		end while (sb.pending_verdicts.size() != 0 && guard < IDLE_LIMIT);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_mode(logic [1:0] m);
		cfg_data  <= m;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.set_mode(m);
		cfg_valid <= 1'b0;
	endtask

	// Mostly uniform values, with small values for ties and the extremes.
	function automatic logic signed [15:0] pick_coord();
		logic signed [15:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: v = 16'($urandom);
			5, 6, 7:       v = 16'($urandom_range(0, 6) - 3);
			8: begin
				case ($urandom_range(0, 3))
					0:       v = 16'sh7FFF;
					1:       v = 16'sh8000;
					2:       v = 16'sh0000;
					default: v = 16'shFFFF;
				endcase
			end
			default: begin
				if ($urandom_range(0, 1)) v = 16'sh7FFF - 16'($urandom_range(0, 3));
				else                      v = 16'sh8000 + 16'($urandom_range(0, 3));
			end
		endcase
		return v;
	endfunction

	// Fill pts with n points; a tidy array is sorted high to low under the
	// current mode, which always forms a heap, then sometimes broken up.
	task automatic build_array(int n, bit tidy);
		mhoc_pkg::coord_t c;
		int               a;
		int               b;
		pts.delete();
		for (int i = 0; i < n; i++) begin
			c.x = pick_coord();
			c.y = pick_coord();
			pts.push_back(c);
		end
		if (tidy) begin
			for (int i = 1; i < n; i++)
				for (int j = i; j > 0 && sb.rank_points(pts[j-1], pts[j]) < 0; j--) begin
					c        = pts[j];
					pts[j]   = pts[j-1];
					pts[j-1] = c;
				end
			if (n > 1 && $urandom_range(0, 3) == 0) begin
				a = $urandom_range(0, n - 1);
				b = $urandom_range(0, n - 1);
				c      = pts[a];
				pts[a] = pts[b];
				pts[b] = c;
			end
		end
	endtask

	initial begin
		logic [1:0] phase_modes [8];
		int         phase_items;
		int         n;
		phase_modes = '{mhoc_pkg::MODE_DIST, mhoc_pkg::MODE_YX, MODE_NONE, mhoc_pkg::MODE_XY,
			mhoc_pkg::MODE_DIST, mhoc_pkg::MODE_YX, mhoc_pkg::MODE_XY, mhoc_pkg::MODE_DIST};

		arst_n      <= 1'b0;
		point_valid <= 1'b0;
		point       <= '0;
		cfg_valid   <= 1'b0;
		cfg_data    <= mhoc_pkg::MODE_XY;
		burst_left  = $urandom_range(1, 40);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset mode is x then y.
		add_pt(32767, 32767);                              // single point, top corner
		send_array();
		add_pt(-32768, -32768);                            // single point, bottom corner
		send_array();
		add_pt(32767, -32768); add_pt(32767, -32768);      // equal parent and child
		add_pt(-32768, 32767); add_pt(-1, 0);
		send_array();
		add_pt(0, 0); add_pt(0, 1);                        // tie on x, child wins on y
		send_array();

		wait_idle();
		write_mode(mhoc_pkg::MODE_YX);
		add_pt(5, -32768); add_pt(-32768, 32767);          // child above on y
		send_array();
		add_pt(0, 32767); add_pt(32767, 0); add_pt(-32768, 0);
		send_array();

		wait_idle();
		write_mode(mhoc_pkg::MODE_DIST);
		add_pt(-32768, -32768); add_pt(32767, 32767); add_pt(0, 0); // largest squares
		send_array();
		add_pt(3, 4); add_pt(5, 0);                        // same distance, x breaks tie
		send_array();

		wait_idle();
		write_mode(MODE_NONE);
		add_pt(0, 0); add_pt(100, 100); add_pt(-32768, 32767);     // never out of order
		send_array();

		// Random phases, one mode each. Every other phase opens with an array
		// around capacity, so points past the store may be dropped.
		for (int ph = 0; ph < 8; ph++) begin
			wait_idle();
			write_mode(phase_modes[ph]);
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				if (phase_items == 0 && ph % 2 == 0) n = $urandom_range(126, 140);
				else if ($urandom_range(0, 99) < 3)  n = $urandom_range(120, 140);
				else if ($urandom_range(0, 99) < 75) n = $urandom_range(1, 16);
				else                                 n = $urandom_range(17, 60);
				build_array(n, $urandom_range(0, 99) < 85);
				phase_items += n;
				send_array();
			end
		end

		wait_idle();
		sb.close_out();
		if (sb.errors == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/mhoc_pkg.sv
rtl/core/mhoc_store.sv
rtl/core/mhoc_order.sv
rtl/core/max_heap_order_checker.sv
tb/max_heap_order_checker_tb.sv
